// ----- rtl/job_queue_with_keyed_removal_unit_macros.svh -----
// Assertion macros for the job queue with keyed removal.
`ifndef JOB_QUEUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH
`define JOB_QUEUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define JQKR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JQKR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JQKR_ASSERT(lbl, prop, msg)
`define JQKR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/jqkr_pkg.sv -----
// Types and constants shared by the job queue with keyed removal.
`timescale 1ns / 1ps
`default_nettype none

package jqkr_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned JOB_W     = 16;
  localparam int unsigned PID_W     = 22;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned ENTRY_W   = JOB_W + PID_W + 1;

  typedef enum logic [1:0] {
    FUNC_INSERT     = 2'd0,
    FUNC_POP_OLDEST = 2'd1,
    FUNC_DEL_JOB    = 2'd2,
    FUNC_DEL_PID    = 2'd3
  } jqkr_func_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } jqkr_status_e;

  typedef struct packed {
    logic             run;
    logic [PID_W-1:0] pid;
    logic [JOB_W-1:0] job;
  } jqkr_entry_t;

  typedef struct packed {
    jqkr_func_e  func;
    jqkr_entry_t entry;
  } jqkr_req_t;

  typedef struct packed {
    jqkr_status_e     status;
    jqkr_entry_t      entry;
    logic [OCC_W-1:0] occ;
  } jqkr_res_t;

endpackage

`default_nettype wire

// ----- rtl/jqkr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module jqkr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/jqkr_ctrl.sv -----
// List controller: age-ordered linked list in RAM, free-slot stack, keyed scan.
`timescale 1ns / 1ps
`default_nettype none

`include "job_queue_with_keyed_removal_unit_macros.svh"

module jqkr_ctrl
  import jqkr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire jqkr_req_t req_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output jqkr_res_t      res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e       state_q, state_d;
  jqkr_req_t    req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] newest_q, newest_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [AW-1:0] cur_q, cur_d;
  logic          use_free_q, use_free_d;
  jqkr_status_e  stat_q, stat_d;
  jqkr_entry_t   rem_q, rem_d;

  // RAM ports
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] free_raddr;
  jqkr_entry_t   ent_rdata;
  logic [AW-1:0] newer_rdata, older_rdata, free_rdata;
  logic          ent_we, newer_we, older_we, free_we;
  logic [AW-1:0] ent_waddr, newer_waddr, older_waddr, free_waddr;
  jqkr_entry_t   ent_wdata;
  logic [AW-1:0] newer_wdata, older_wdata, free_wdata;

  logic          hit;
  logic [AW-1:0] slot;

  jqkr_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ent_rdata)
  );

  jqkr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (newer_we),
    .waddr_i (newer_waddr),
    .wdata_i (newer_wdata),
    .raddr_i (rd_addr),
    .rdata_o (newer_rdata)
  );

  jqkr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (older_we),
    .waddr_i (older_waddr),
    .wdata_i (older_wdata),
    .raddr_i (rd_addr),
    .rdata_o (older_rdata)
  );

  jqkr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = '{status: stat_q, entry: rem_q, occ: OCC_W'(cnt_q)};

  // top of the free-slot stack
  assign free_raddr = AW'(sp_q - CW'(1));

  assign slot = use_free_q ? free_rdata : fill_q[AW-1:0];

  assign hit = (req_q.func == FUNC_POP_OLDEST) ||
               ((req_q.func == FUNC_DEL_JOB) && (ent_rdata.job == req_q.entry.job)) ||
               ((req_q.func == FUNC_DEL_PID) && (ent_rdata.pid == req_q.entry.pid));

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    sp_d       = sp_q;
    idx_d      = idx_q;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    cur_d      = cur_q;
    use_free_d = use_free_q;
    stat_d     = stat_q;
    rem_d      = rem_q;

    rd_addr     = cur_q;
    ent_we      = 1'b0;
    ent_waddr   = slot;
    ent_wdata   = req_q.entry;
    newer_we    = 1'b0;
    newer_waddr = newest_q;
    newer_wdata = slot;
    older_we    = 1'b0;
    older_waddr = slot;
    older_wdata = newest_q;
    free_we     = 1'b0;
    free_waddr  = sp_q[AW-1:0];
    free_wdata  = cur_q;

    unique case (state_q)
      ST_IDLE: begin
        rd_addr = (req_i.func == FUNC_POP_OLDEST) ? oldest_q : newest_q;
        if (req_valid_i) begin
          req_d  = req_i;
          cur_d  = rd_addr;
          idx_d  = '0;
          rem_d  = '0;
          if (req_i.func == FUNC_INSERT) begin
            if (cnt_q == FULL_CNT) begin
              stat_d  = STAT_FULL;
              state_d = ST_RESP;
            end else begin
              use_free_d = (sp_q != '0);
              state_d    = ST_INS;
            end
          end else if (cnt_q == '0) begin
            stat_d  = STAT_NONE;
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_INS: begin
        ent_we   = 1'b1;
        older_we = 1'b1;
        if (cnt_q != '0) begin
          newer_we = 1'b1;
        end else begin
          oldest_d = slot;
        end
        newest_d = slot;
        cnt_d    = cnt_q + CW'(1);
        if (use_free_q) begin
          sp_d = sp_q - CW'(1);
        end else begin
          fill_d = fill_q + CW'(1);
        end
        stat_d  = STAT_DONE;
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        if (hit) begin
          rem_d  = ent_rdata;
          stat_d = STAT_DONE;
          // unlink cur_q
          if (cnt_q <= CW'(1)) begin
            newest_d = '0;
            oldest_d = '0;
          end else begin
            if (cur_q == newest_q) begin
              newest_d = older_rdata;
            end else begin
              older_we    = 1'b1;
              older_waddr = newer_rdata;
              older_wdata = older_rdata;
            end
            if (cur_q == oldest_q) begin
              oldest_d = newer_rdata;
            end else begin
              newer_we    = 1'b1;
              newer_waddr = older_rdata;
              newer_wdata = newer_rdata;
            end
          end
          free_we = 1'b1;
          sp_d    = sp_q + CW'(1);
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_RESP;
        end else if ((idx_q + CW'(1)) == cnt_q) begin
          stat_d  = STAT_NONE;
          state_d = ST_RESP;
        end else begin
          rd_addr = older_rdata;
          cur_d   = older_rdata;
          idx_d   = idx_q + CW'(1);
        end
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= '0;
      cnt_q      <= '0;
      fill_q     <= '0;
      sp_q       <= '0;
      idx_q      <= '0;
      newest_q   <= '0;
      oldest_q   <= '0;
      cur_q      <= '0;
      use_free_q <= 1'b0;
      stat_q     <= STAT_DONE;
      rem_q      <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      cnt_q      <= cnt_d;
      fill_q     <= fill_d;
      sp_q       <= sp_d;
      idx_q      <= idx_d;
      newest_q   <= newest_d;
      oldest_q   <= oldest_d;
      cur_q      <= cur_d;
      use_free_q <= use_free_d;
      stat_q     <= stat_d;
      rem_q      <= rem_d;
    end
  end

  `JQKR_ASSERT(a_slot_balance, (({1'b0, cnt_q} + {1'b0, sp_q}) == {1'b0, fill_q}), "slot accounting lost a slot")
  `JQKR_ASSERT(a_fill_bound, (fill_q <= FULL_CNT), "fill count beyond depth")
  `JQKR_ASSERT(a_scan_bound, ((state_q == ST_SCAN) |-> ((cnt_q != '0) && (idx_q < cnt_q))), "scan past list end")
  `JQKR_ASSERT(a_ins_room, ((state_q == ST_INS) |-> ((cnt_q < FULL_CNT) && (use_free_q == (sp_q != '0)))), "insert without a free slot")

endmodule

`default_nettype wire

// ----- rtl/job_queue_with_keyed_removal_unit.sv -----
// Job queue with keyed removal: stream ports, list controller and output register.
//
// Usage:
//   Slave channel s_axis carries one operation per transfer: tuser is the
//   operation (insert newest, remove oldest, remove by job id, remove by
//   process id), tdata the job id, process id and running flag.
//   Master channel m_axis returns exactly one result per operation: tuser is
//   the status (done, empty or no match, full), tdata the removed entry and
//   the number of entries held afterwards.
//   Entries live in RAM as an age-ordered doubly linked list; freed slots go
//   to a free-slot stack in RAM.
//   Path per operation, from input transfer to the output register:
//   insert passes the insert state; rejected insert and remove on empty go
//   straight to the result state; removes pass the scan state, which
//   examines entries (at most DEPTH), one entry per cycle, bounded by the
//   registered link RAM read that yields the next older slot.
//   One operation is in flight at a time; the next input transfer is taken
//   once the result has moved to the output register, even while that
//   register waits on a stalled receiver. A stall of two results holds the
//   controller in its result state and s_axis_tready low.
//   Reset empties the queue at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module job_queue_with_keyed_removal_unit
  import jqkr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // job_id[15:0], process_id[37:16], running_in[38]
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_job_id[15:0], out_process_id[37:16],
                                          // out_running[38], occupancy[43:39]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  jqkr_req_t req;
  jqkr_res_t res;
  logic      res_valid, res_ready;
  logic      m_valid_q, m_valid_d;
  jqkr_res_t m_q, m_d;

  assign req.func      = jqkr_func_e'(s_axis_tuser);
  assign req.entry.job = s_axis_tdata[15:0];
  assign req.entry.pid = s_axis_tdata[37:16];
  assign req.entry.run = s_axis_tdata[38];

  jqkr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_d       = m_q;
    if (res_ready) begin
      m_valid_d = res_valid;
      if (res_valid) begin
        m_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_q       <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      m_q       <= m_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_q.status;
  assign m_axis_tdata  = {4'b0, m_q.occ, m_q.entry.run, m_q.entry.pid, m_q.entry.job};

endmodule

`default_nettype wire

// ----- sim/tb_job_queue_with_keyed_removal_unit.sv -----
// Testbench for the job queue with keyed removal: directed and random operations vs. a queue model.
`timescale 1ns / 1ps

module tb_job_queue_with_keyed_removal_unit;
  import jqkr_pkg::*;

  localparam int unsigned QDEPTH      = DEPTH_DEF;
  localparam int          LONG_HOLD   = 300;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 2 * QDEPTH + 8;

  typedef struct packed {
    jqkr_status_e     status;
    logic [JOB_W-1:0] job;
    logic [PID_W-1:0] pid;
    logic             run;
    logic [OCC_W-1:0] occ;
  } job_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // job_id, process_id, running_in, pad
  logic [1:0]  s_axis_tuser  = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // out_job_id, out_process_id, out_running, occupancy, pad
  logic [1:0]  m_axis_tuser;        // status

  jqkr_entry_t held_jobs[$];        // oldest at index 0
  job_result_t awaited_results[$];

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_ack       = 1'b0;
  int cycles         = 0;

  job_queue_with_keyed_removal_unit #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles = cycles + 1;
    end
    $display("FAIL");
    $finish;
  end

  // Applies one operation to the model; keyed removal takes the newest match.
  function automatic job_result_t apply_job_op(jqkr_func_e func, jqkr_entry_t req);
    job_result_t res;
    int          hit;
    int          i;
    res        = '0;
    res.status = STAT_NONE;
    hit        = -1;
    case (func)
      FUNC_INSERT: begin
        if (held_jobs.size() >= QDEPTH) begin
          res.status = STAT_FULL;
        end else begin
          held_jobs.push_back(req);
          res.status = STAT_DONE;
        end
      end
      FUNC_POP_OLDEST: begin
        if (held_jobs.size() != 0) hit = 0;
      end
      default: begin
        for (i = held_jobs.size() - 1; i >= 0 && hit < 0; i--) begin
          if (func == FUNC_DEL_JOB ? held_jobs[i].job == req.job
                                   : held_jobs[i].pid == req.pid) hit = i;
        end
      end
    endcase
    if (hit >= 0) begin
      res.job    = held_jobs[hit].job;
      res.pid    = held_jobs[hit].pid;
      res.run    = held_jobs[hit].run;
      res.status = STAT_DONE;
      held_jobs.delete(hit);
    end
    res.occ = OCC_W'(held_jobs.size());
    return res;
  endfunction

  task automatic send_job_op(jqkr_func_e func, logic [JOB_W-1:0] job,
                             logic [PID_W-1:0] pid, logic run);
    jqkr_entry_t req;
    req.job = job;
    req.pid = pid;
    req.run = run;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, req};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_results.push_back(apply_job_op(func, req));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_store();
    send_job_op(FUNC_POP_OLDEST, 16'h0000, 22'h000000, 1'b0);
    send_job_op(FUNC_DEL_JOB,    16'hFFFF, 22'h3FFFFF, 1'b1);
    send_job_op(FUNC_DEL_PID,    16'h0000, 22'h3FFFFF, 1'b0);
    // single entry leaves by key, store empties again
    send_job_op(FUNC_INSERT,     16'h1357, 22'h2468AC, 1'b1);
    send_job_op(FUNC_DEL_PID,    16'h0000, 22'h2468AC, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_full_store();
    int               i;
    logic [JOB_W-1:0] job;
    logic [PID_W-1:0] pid;
    for (i = 0; i < QDEPTH; i++) begin
      case (i)
        0:       begin job = 16'h0000; pid = 22'h000000; end
        1:       begin job = 16'hFFFF; pid = 22'h3FFFFF; end
        2:       begin job = 16'h5555; pid = 22'h155555; end
        3:       begin job = 16'hAAAA; pid = 22'h2AAAAA; end
        default: begin job = 16'h0100 | JOB_W'(i & 3); pid = 22'h001000 + PID_W'(i / 2); end
      endcase
      send_job_op(FUNC_INSERT, job, pid, i[0]);
    end
    send_job_op(FUNC_INSERT, 16'h1234, 22'h001234, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_keyed_removal();
    send_job_op(FUNC_DEL_JOB,    16'h0100, 22'h000000, 1'b0);  // duplicates: newest goes
    send_job_op(FUNC_DEL_PID,    16'h0000, 22'h001002, 1'b0);
    send_job_op(FUNC_DEL_JOB,    16'h0103, 22'h000000, 1'b1);  // newest entry
    send_job_op(FUNC_DEL_JOB,    16'h4321, 22'h3FFFFF, 1'b0);  // no match
    send_job_op(FUNC_DEL_PID,    16'hFFFF, 22'h3FFFFE, 1'b1);  // no match
    send_job_op(FUNC_POP_OLDEST, 16'h0000, 22'h000000, 1'b0);
    send_job_op(FUNC_DEL_PID,    16'h0000, 22'h3FFFFF, 1'b0);  // now the oldest
    wait_results_drained();
  endtask

  task automatic run_random_ops(int count);
    int               n;
    int               r;
    int               ins_pct;
    int unsigned      idx;
    jqkr_func_e       func;
    logic [JOB_W-1:0] job;
    logic [PID_W-1:0] pid;
    for (n = 0; n < count; n++) begin
      ins_pct = ((n / 40) % 2 == 0) ? 75 : 30;
      r       = $urandom_range(99);
      if (r < ins_pct) begin
        func = FUNC_INSERT;
      end else begin
        case ($urandom_range(2))
          0:       func = FUNC_POP_OLDEST;
          1:       func = FUNC_DEL_JOB;
          default: func = FUNC_DEL_PID;
        endcase
      end
      job = $urandom_range(1) ? JOB_W'($urandom_range(15)) : JOB_W'($urandom);
      pid = $urandom_range(1) ? PID_W'($urandom_range(15)) : PID_W'($urandom);
      if (func != FUNC_INSERT && held_jobs.size() != 0 && $urandom_range(9) < 8) begin
        idx = $urandom_range(held_jobs.size() - 1);
        if (func == FUNC_DEL_JOB) job = held_jobs[idx].job;
        else                      pid = held_jobs[idx].pid;
      end
      send_job_op(func, job, pid, 1'($urandom_range(1)));
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_random_ops(count);
  endtask

  task automatic test_receiver_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req      <= ~hold_req;
    run_random_ops(12);
  endtask

  // receiver; a requested long hold is counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_result
    job_result_t      want;
    jqkr_entry_t      got;
    logic [OCC_W-1:0] got_occ;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got     = m_axis_tdata[ENTRY_W-1:0];
      got_occ = m_axis_tdata[ENTRY_W +: OCC_W];
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count = fail_count + 1;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          fail_count = fail_count + 1;
        end
        if (got.job !== want.job) begin
          $error("out_job_id: expected %0h, actual %0h", want.job, got.job);
          fail_count = fail_count + 1;
        end
        if (got.pid !== want.pid) begin
          $error("out_process_id: expected %0h, actual %0h", want.pid, got.pid);
          fail_count = fail_count + 1;
        end
        if (got.run !== want.run) begin
          $error("out_running: expected %0d, actual %0d", want.run, got.run);
          fail_count = fail_count + 1;
        end
        if (got_occ !== want.occ) begin
          $error("occupancy: expected %0d, actual %0d", want.occ, got_occ);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_full_store();
    test_keyed_removal();
    test_random_traffic(360, 0, 0);
    test_random_traffic(300, 88, 0);
    test_random_traffic(300, 0, 88);
    test_random_traffic(300, 13, 13);
    test_receiver_backpressure();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
